[design/sprite_line_buffer_collision_assert.svh]
// assertion macro used by the checker
`ifndef SPRITE_LINE_BUFFER_COLLISION_ASSERT_SVH
`define SPRITE_LINE_BUFFER_COLLISION_ASSERT_SVH
// property checked on every rising clock edge outside reset
`define SLBC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`endif

[design/slbc_pkg.sv]
`default_nettype none
package slbc_pkg;
   localparam int LineWidth   = 640;
   localparam int SpriteCount = 64;
   localparam int ColW  = $clog2(LineWidth);
   localparam int IdW   = $clog2(SpriteCount);
   localparam int OwnW  = 7;

   localparam logic [2:0] ACT_CLR_LINE = 3'd0;
   localparam logic [2:0] ACT_CLR_COLL = 3'd1;
   localparam logic [2:0] ACT_SET_MASK = 3'd2;
   localparam logic [2:0] ACT_DRAW     = 3'd3;
   localparam logic [2:0] ACT_RD_PIX   = 3'd4;
   localparam logic [2:0] ACT_RD_COLL  = 3'd5;
endpackage
`default_nettype wire

[design/slbc_ram.sv]
`default_nettype none
module slbc_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[design/sprite_line_buffer_collision.sv]
// steps: read pixel or collision reads the memories, then captures the result; set mask and
// unused actions go straight to the result; clear line sweeps the owner memory and clear
// collisions the collision registers; draw skips, claims or records a collision per column
// throughput: one item at a time; next accept the cycle after the result beat is taken
// reset: synchronous; sweeps owner, collision and mask memories to zero before the first
// item is accepted
`default_nettype none
module sprite_line_buffer_collision (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [23:0] csr_background_colour,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [5:0]  req_sprite_id,
   input  wire logic signed [11:0] req_x_start,
   input  wire logic [5:0]  req_row_width,
   input  wire logic [31:0] req_row_bits,
   input  wire logic [23:0] req_sprite_colour,
   input  wire logic [7:0]  req_mask_value,
   input  wire logic [9:0]  req_pixel_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_pixel_owner,
   output logic [23:0]      rsp_pixel_colour,
   output logic [7:0]       rsp_collision_bits
);
   localparam int ColW = slbc_pkg::ColW;
   localparam int IdW  = slbc_pkg::IdW;
   localparam int OwnW = slbc_pkg::OwnW;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_INIT  = 4'd1;
   localparam logic [3:0] ST_CLRL  = 4'd2;
   localparam logic [3:0] ST_CLRC  = 4'd3;
   localparam logic [3:0] ST_DRD   = 4'd4;  // draw: issue owner read
   localparam logic [3:0] ST_DWR   = 4'd5;  // draw: decide and write
   localparam logic [3:0] ST_CWR   = 4'd6;  // draw: collision other reg rmw
   localparam logic [3:0] ST_CWR2  = 4'd7;  // draw: own reg write
   localparam logic [3:0] ST_RD    = 4'd8;
   localparam logic [3:0] ST_RD2   = 4'd9;
   localparam logic [3:0] ST_RESP  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [10:0] cnt_ff, cnt_in;          // init/clear sweep counter
   logic [10:0] cnt_end;
   logic [23:0] bg_ff, bg_in;
   logic [2:0]  act_ff, act_in;
   logic [IdW-1:0] id_ff, id_in;
   logic signed [12:0] col_ff, col_in;
   logic [5:0]  left_ff, left_in;
   logic [31:0] bits_ff, bits_in;
   logic [23:0] colour_ff, colour_in;
   logic [ColW-1:0] pix_ff, pix_in;
   logic        pix_ok_ff, pix_ok_in, id_ok_ff, id_ok_in;
   logic [IdW-1:0] other_ff, other_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  own_o_ff, own_o_in;
   logic [23:0] col_o_ff, col_o_in;
   logic [7:0]  coll_o_ff, coll_o_in;

   // memories
   logic            own_we, col_we, coll_we, mask_we;
   logic [ColW-1:0] own_wa, own_ra;
   logic [OwnW-1:0] own_wd, own_rd;
   logic [23:0]     col_rd;
   logic [IdW-1:0]  coll_wa, coll_ra;
   logic [7:0]      coll_wd, coll_rd;
   logic [IdW-1:0]  mask_wa, mask_ra;
   logic [7:0]      mask_wd, mask_rd;

   slbc_ram #(.Width(OwnW), .Depth(slbc_pkg::LineWidth)) u_owner (
      .clock, .wr_en(own_we), .wr_addr(own_wa), .wr_data(own_wd),
      .rd_addr(own_ra), .rd_data(own_rd));
   slbc_ram #(.Width(24), .Depth(slbc_pkg::LineWidth)) u_colour (
      .clock, .wr_en(col_we), .wr_addr(own_wa), .wr_data(colour_ff),
      .rd_addr(own_ra), .rd_data(col_rd));
   slbc_ram #(.Width(8), .Depth(slbc_pkg::SpriteCount)) u_coll (
      .clock, .wr_en(coll_we), .wr_addr(coll_wa), .wr_data(coll_wd),
      .rd_addr(coll_ra), .rd_data(coll_rd));
   slbc_ram #(.Width(8), .Depth(slbc_pkg::SpriteCount)) u_mask (
      .clock, .wr_en(mask_we), .wr_addr(mask_wa), .wr_data(mask_wd),
      .rd_addr(mask_ra), .rd_data(mask_rd));

   logic cur_bit, col_in_line, own_here;
   logic req_fire, req_id_ok;

   assign cur_bit  = bits_ff[31];
   assign col_in_line = (col_ff >= 13'sd0) &&
                        (col_ff < $signed(13'(slbc_pkg::LineWidth)));
   assign own_here = own_rd != '0;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign req_id_ok = {1'b0, req_sprite_id} < 7'(slbc_pkg::SpriteCount);
   assign cnt_end   = (state_ff == ST_CLRC) ? 11'(slbc_pkg::SpriteCount) :
                                              11'(slbc_pkg::LineWidth);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_owner = own_o_ff;
   assign rsp_pixel_colour = col_o_ff;
   assign rsp_collision_bits = coll_o_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      col_in = col_ff;
      left_in = left_ff;
      bits_in = bits_ff;
      other_in = other_ff;
      bg_in = bg_ff;
      act_in = act_ff;
      id_in = id_ff;
      id_ok_in = id_ok_ff;
      pix_in = pix_ff;
      pix_ok_in = pix_ok_ff;
      colour_in = colour_ff;
      rsp_valid_in = rsp_valid_ff;
      own_o_in = own_o_ff;
      col_o_in = col_o_ff;
      coll_o_in = coll_o_ff;
      own_we = 1'b0; col_we = 1'b0; coll_we = 1'b0; mask_we = 1'b0;
      own_wa = col_ff[ColW-1:0];
      own_ra = col_ff[ColW-1:0];
      own_wd = OwnW'(id_ff) + OwnW'(1);
      coll_wa = id_ff; coll_ra = id_ff; coll_wd = '0;
      mask_wa = id_ff; mask_ra = id_ff; mask_wd = '0;
      if (csr_valid && csr_ready) bg_in = csr_background_colour;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in = '0;
               act_in = req_action;
               id_in = req_sprite_id[IdW-1:0];
               id_ok_in = req_id_ok;
               pix_in = req_pixel_index[ColW-1:0];
               pix_ok_in = {1'b0, req_pixel_index} < 11'(slbc_pkg::LineWidth);
               colour_in = req_sprite_colour;
               col_in = 13'(req_x_start);
               // clamp width, zero for invalid sprite
               if (req_id_ok)
                  left_in = (req_row_width > 6'd32) ? 6'd32 : req_row_width;
               else
                  left_in = 6'd0;
               bits_in = (req_row_width >= 6'd32) ? req_row_bits :
                         (req_row_bits << (6'd32 - req_row_width));
               own_o_in = '0; col_o_in = '0; coll_o_in = '0;
               unique case (req_action)
                  slbc_pkg::ACT_CLR_LINE: state_in = ST_CLRL;
                  slbc_pkg::ACT_CLR_COLL: state_in = ST_CLRC;
                  slbc_pkg::ACT_DRAW:     state_in = ST_DRD;
                  slbc_pkg::ACT_RD_PIX, slbc_pkg::ACT_RD_COLL: state_in = ST_RD;
                  default: state_in = ST_RESP;
               endcase
               if (req_action == slbc_pkg::ACT_SET_MASK && req_id_ok) begin
                  mask_we = 1'b1;
                  mask_wa = req_sprite_id[IdW-1:0];
                  mask_wd = req_mask_value;
               end
            end
         end
         ST_INIT, ST_CLRL, ST_CLRC: begin
            own_we = (state_ff != ST_CLRC) && (cnt_ff < 11'(slbc_pkg::LineWidth));
            own_wa = cnt_ff[ColW-1:0];
            own_wd = '0;
            coll_we = (state_ff != ST_CLRL) && (cnt_ff < 11'(slbc_pkg::SpriteCount));
            coll_wa = cnt_ff[IdW-1:0];
            mask_we = (state_ff == ST_INIT) && (cnt_ff < 11'(slbc_pkg::SpriteCount));
            mask_wa = cnt_ff[IdW-1:0];
            cnt_in = cnt_ff + 11'd1;
            if (cnt_ff == cnt_end) state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_RESP;
         end
         ST_DRD: begin
            // skip to next set bit in range
            if (left_ff == 6'd0) begin
               state_in = ST_RESP;
            end else if (cur_bit && col_in_line) begin
               state_in = ST_DWR;
            end else begin
               col_in = col_ff + 13'sd1;
               left_in = left_ff - 6'd1;
               bits_in = bits_ff << 1;
            end
         end
         ST_DWR: begin
            // mask read of own id issued here
            if (own_here) begin
               other_in = own_rd[IdW-1:0] - IdW'(1);
               coll_ra = own_rd[IdW-1:0] - IdW'(1);
               state_in = ST_CWR;
            end else begin
               own_we = 1'b1;
               col_we = 1'b1;
               state_in = ST_DRD;
               col_in = col_ff + 13'sd1;
               left_in = left_ff - 6'd1;
               bits_in = bits_ff << 1;
            end
         end
         ST_CWR: begin
            // coll_rd holds other's register, mask_rd own mask
            coll_we = 1'b1;
            coll_wa = other_ff;
            coll_wd = coll_rd | mask_rd;
            coll_ra = id_ff;
            mask_ra = other_ff;
            state_in = ST_CWR2;
         end
         ST_CWR2: begin
            // coll_rd holds own register, mask_rd other's mask
            coll_we = 1'b1;
            coll_wa = id_ff;
            coll_wd = coll_rd | mask_rd;
            state_in = ST_DRD;
            col_in = col_ff + 13'sd1;
            left_in = left_ff - 6'd1;
            bits_in = bits_ff << 1;
         end
         ST_RD:  begin
            own_ra = pix_ff;
            coll_ra = id_ff;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            // result capture
            if (act_ff == slbc_pkg::ACT_RD_PIX) begin
               if (pix_ok_ff && own_here) begin
                  own_o_in = own_rd; col_o_in = col_rd;
               end else begin
                  col_o_in = bg_ff;
               end
            end else if (id_ok_ff) begin
               coll_o_in = coll_rd;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         bg_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         bg_ff <= bg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      col_ff <= col_in;
      left_ff <= left_in;
      bits_ff <= bits_in;
      other_ff <= other_in;
      act_ff <= act_in;
      id_ff <= id_in;
      id_ok_ff <= id_ok_in;
      pix_ff <= pix_in;
      pix_ok_ff <= pix_ok_in;
      colour_ff <= colour_in;
      own_o_ff <= own_o_in;
      col_o_ff <= col_o_in;
      coll_o_ff <= coll_o_in;
   end
endmodule
`default_nettype wire

[design/slbc_checker.sv]
`default_nettype none
`include "sprite_line_buffer_collision_assert.svh"
module slbc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [6:0] rsp_pixel_owner,
   input wire logic [23:0] rsp_pixel_colour,
   input wire logic [7:0] rsp_collision_bits
);
   logic [38:0] rsp_payload;

   assign rsp_payload = {rsp_pixel_owner, rsp_pixel_colour, rsp_collision_bits};

   // no new item while a result waits
   `SLBC_ASSERT(a_no_overlap, clock, reset, rsp_valid |-> !req_ready)
   // one item at a time: input closes after an accepted beat
   `SLBC_ASSERT(a_single, clock, reset, req_valid && req_ready |=> !req_ready)
   // result beat holds while stalled
   `SLBC_ASSERT(a_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
   // owner and collision fields never both nonzero
   `SLBC_ASSERT(a_excl, clock, reset, rsp_valid |-> (rsp_pixel_owner == 7'd0 || rsp_collision_bits == 8'd0))
endmodule

bind sprite_line_buffer_collision slbc_checker u_slbc_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_pixel_owner, .rsp_pixel_colour, .rsp_collision_bits);
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;
   localparam logic [2:0] ACT_SPARE6 = 3'd6;
   localparam logic [2:0] ACT_SPARE7 = 3'd7;
   localparam int STALL_LIMIT = 6000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [2:0]         action;
      logic [5:0]         sprite_id;
      logic signed [11:0] x_start;
      logic [5:0]         row_width;
      logic [31:0]        row_bits;
      logic [23:0]        sprite_colour;
      logic [7:0]         mask_value;
      logic [9:0]         pixel_index;
   } line_op_type;

   typedef struct {
      logic [6:0]  owner;
      logic [23:0] colour;
      logic [7:0]  coll;
   } readback_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [23:0] csr_background_colour = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic [5:0]  req_sprite_id = '0;
   logic signed [11:0] req_x_start = '0;
   logic [5:0]  req_row_width = '0;
   logic [31:0] req_row_bits = '0;
   logic [23:0] req_sprite_colour = '0;
   logic [7:0]  req_mask_value = '0;
   logic [9:0]  req_pixel_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [6:0]  rsp_pixel_owner;
   logic [23:0] rsp_pixel_colour;
   logic [7:0]  rsp_collision_bits;

   sprite_line_buffer_collision dut (.*);

   always #4 clock = ~clock;

   // shadow copy of the line, the collision registers and the class masks
   logic [6:0]  owner_mirror [slbc_pkg::LineWidth];
   logic [23:0] colour_mirror [slbc_pkg::LineWidth];
   logic [7:0]  coll_mirror [slbc_pkg::SpriteCount];
   logic [7:0]  class_mirror [slbc_pkg::SpriteCount];
   logic [23:0] bg_mirror = '0;

   line_op_type  pending_ops [$];
   readback_type expected_reads [$];
   int        errors = 0;
   int        beats_in = 0;
   int        beats_out = 0;
   int        draws_seen = 0;
   int        hits_seen = 0;
   bit        quiet = 0;
   bit        hold_req = 0;

   initial begin
      foreach (owner_mirror[i]) owner_mirror[i] = '0;
      foreach (colour_mirror[i]) colour_mirror[i] = '0;
      foreach (coll_mirror[i]) coll_mirror[i] = '0;
      foreach (class_mirror[i]) class_mirror[i] = '0;
   end

   // apply one line op to the shadow state and return its readback
   function automatic readback_type compose_line_op(line_op_type op);
      readback_type rb;
      int w;
      int col;
      logic [6:0] own;
      rb = '{default: '0};
      case (op.action)
         slbc_pkg::ACT_CLR_LINE: begin
            foreach (owner_mirror[i]) owner_mirror[i] = '0;
         end
         slbc_pkg::ACT_CLR_COLL: begin
            foreach (coll_mirror[i]) coll_mirror[i] = '0;
         end
         slbc_pkg::ACT_SET_MASK: class_mirror[op.sprite_id] = op.mask_value;
         slbc_pkg::ACT_DRAW: begin
            draws_seen++;
            w = (op.row_width > 32) ? 32 : op.row_width;
            for (int i = 0; i < w; i++) begin
               col = int'(op.x_start) + i;
               if (op.row_bits[w-1-i] && col >= 0 && col < slbc_pkg::LineWidth) begin
                  own = owner_mirror[col];
                  if (own != 0) begin
                     hits_seen++;
                     coll_mirror[own-1] |= class_mirror[op.sprite_id];
                     coll_mirror[op.sprite_id] |= class_mirror[own-1];
                  end else begin
                     colour_mirror[col] = op.sprite_colour;
                     owner_mirror[col] = 7'(op.sprite_id) + 7'd1;
                  end
               end
            end
         end
         slbc_pkg::ACT_RD_PIX: begin
            if (op.pixel_index < slbc_pkg::LineWidth &&
                owner_mirror[op.pixel_index] != 0) begin
               rb.owner = owner_mirror[op.pixel_index];
               rb.colour = colour_mirror[op.pixel_index];
            end else begin
               rb.colour = bg_mirror;
            end
         end
         slbc_pkg::ACT_RD_COLL: rb.coll = coll_mirror[op.sprite_id];
         default: ;
      endcase
      return rb;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h (result %0d)",
               field, got, want, beats_out);
      errors++;
   endtask

   // driver: pops pending ops, random gaps between beats
   int gap_left = 0;
   always @(posedge clock) begin
      line_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            op = '{req_action, req_sprite_id, req_x_start, req_row_width,
                   req_row_bits, req_sprite_colour, req_mask_value, req_pixel_index};
            expected_reads.push_back(compose_line_op(op));
            beats_in++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               op = pending_ops.pop_front();
               req_valid <= 1'b1;
               req_action <= op.action;
               req_sprite_id <= op.sprite_id;
               req_x_start <= op.x_start;
               req_row_width <= op.row_width;
               req_row_bits <= op.row_bits;
               req_sprite_colour <= op.sprite_colour;
               req_mask_value <= op.mask_value;
               req_pixel_index <= op.pixel_index;
               if (!quiet && $urandom_range(0, 5) == 0)
                  gap_left = $urandom_range(1, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks readbacks and throttles rsp_ready
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      readback_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (expected_reads.size() == 0) begin
               report("result count", 32'(beats_out), 32'(beats_in));
            end else begin
               want = expected_reads.pop_front();
               if (rsp_pixel_owner !== want.owner)
                  report("pixel_owner", rsp_pixel_owner, want.owner);
               if (rsp_pixel_colour !== want.colour)
                  report("pixel_colour", rsp_pixel_colour, want.colour);
               if (rsp_collision_bits !== want.coll)
                  report("collision_bits", rsp_collision_bits, want.coll);
            end
         end
         if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic line_op_type any_op();
      line_op_type op;
      op.action = 3'($urandom_range(0, 7));
      op.sprite_id = 6'($urandom);
      op.x_start = 12'($urandom);
      op.row_width = 6'($urandom);
      op.row_bits = $urandom;
      op.sprite_colour = 24'($urandom);
      op.mask_value = 8'($urandom);
      op.pixel_index = 10'($urandom);
      return op;
   endfunction

   function automatic line_op_type draw_op(int id, int x, int w, logic [31:0] bits);
      line_op_type op;
      op = any_op();
      op.action = slbc_pkg::ACT_DRAW;
      op.sprite_id = 6'(id);
      op.x_start = 12'(x);
      op.row_width = 6'(w);
      op.row_bits = bits;
      return op;
   endfunction

   function automatic line_op_type plain_op(logic [2:0] act, int id, int pix);
      line_op_type op;
      op = any_op();
      op.action = act;
      op.sprite_id = 6'(id);
      op.pixel_index = 10'(pix);
      return op;
   endfunction

   // mostly draws near the visible line with readbacks, a little noise
   function automatic line_op_type scene_op();
      line_op_type op;
      int r;
      op = any_op();
      if ($urandom_range(0, 1) == 0) op.sprite_id = 6'($urandom_range(0, 7));
      if ($urandom_range(0, 5) != 0) op.x_start = 12'($urandom_range(0, 700) - 40);
      if ($urandom_range(0, 6) != 0) op.row_width = 6'($urandom_range(1, 32));
      if ($urandom_range(0, 6) != 0) op.pixel_index = 10'($urandom_range(0, 660));
      r = $urandom_range(0, 99);
      if (r < 2) op.action = slbc_pkg::ACT_CLR_LINE;
      else if (r < 5) op.action = slbc_pkg::ACT_CLR_COLL;
      else if (r < 13) op.action = slbc_pkg::ACT_SET_MASK;
      else if (r < 55) op.action = slbc_pkg::ACT_DRAW;
      else if (r < 83) op.action = slbc_pkg::ACT_RD_PIX;
      else if (r < 97) op.action = slbc_pkg::ACT_RD_COLL;
      else op.action = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
      return op;
   endfunction

   task automatic drain();
      while (pending_ops.size() > 0 || expected_reads.size() > 0 || req_valid)
         @(posedge clock);
      repeat (slbc_pkg::LineWidth + 8) @(posedge clock);
   endtask

   task automatic write_background(logic [23:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_background_colour <= value;
      do @(posedge clock); while (!csr_ready);
      bg_mirror = value;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [23:0] bg_plan [4];
      bg_plan = '{24'hFFFFFF, 24'h000000, 24'($urandom), 24'h5A5A5A};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: clipping, widths, self overlap, range edges, spare actions
      pending_ops.push_back(plain_op(slbc_pkg::ACT_RD_PIX, 0, 5));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_SET_MASK, 1, 0));
      pending_ops[$].mask_value = 8'h81;
      pending_ops.push_back(plain_op(slbc_pkg::ACT_SET_MASK, 2, 0));
      pending_ops[$].mask_value = 8'h7E;
      pending_ops.push_back(plain_op(slbc_pkg::ACT_SET_MASK, 63, 0));
      pending_ops[$].mask_value = 8'hFF;
      pending_ops.push_back(draw_op(1, -5, 32, 32'hFFFFFFFF));
      pending_ops.push_back(draw_op(2, 10, 32, 32'hAAAAAAAA));
      pending_ops.push_back(draw_op(63, 625, 32, 32'hFFFFFFFF));
      pending_ops.push_back(draw_op(1, 0, 0, 32'hFFFFFFFF));
      pending_ops.push_back(draw_op(1, 20, 40, 32'h0000FFFF));
      pending_ops.push_back(draw_op(63, 639, 1, 32'h1));
      pending_ops.push_back(draw_op(2, -2048, 32, 32'hFFFFFFFF));
      pending_ops.push_back(draw_op(2, 2047, 32, 32'hFFFFFFFF));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_RD_PIX, 0, 0));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_RD_PIX, 0, 639));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_RD_PIX, 0, 640));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_RD_PIX, 0, 1023));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_RD_COLL, 1, 0));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_RD_COLL, 2, 0));
      pending_ops.push_back(plain_op(ACT_SPARE6, 1, 0));
      pending_ops.push_back(plain_op(ACT_SPARE7, 1, 0));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_CLR_COLL, 0, 0));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_RD_COLL, 1, 0));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_CLR_LINE, 0, 0));
      pending_ops.push_back(plain_op(slbc_pkg::ACT_RD_PIX, 0, 12));
      drain();

      // random phases, each under a new background colour
      for (int phase = 0; phase < 4; phase++) begin
         write_background(bg_plan[phase]);
         if (phase == 1) hold_req = 1;
         if (phase == 3) quiet = 1;
         repeat (375) pending_ops.push_back(scene_op());
         drain();
      end

      $display("tb: %0d ops in, %0d readbacks checked, %0d draws, %0d overlap pixels",
               beats_in, beats_out, draws_seen, hits_seen);
      $display("tb: backgrounds incl. all-zero and all-one, clipping and spare actions run");
      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
+incdir+design
design/slbc_pkg.sv
design/slbc_ram.sv
design/sprite_line_buffer_collision.sv
design/slbc_checker.sv
tb/tb.sv
